// ===== rtl/mips_subset_execute_unit_defines.svh =====
// assertion macros for the mips subset execute unit
// used by the top level only, needs clk and rst in scope
`ifndef MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define MSEU_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define MSEU_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mseu_pkg.sv =====
// shared types and constants for the mips subset execute unit
// no dependencies
package mseu_pkg;

  localparam int DATA_DEPTH    = 1024;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int DATA_AW       = $clog2(DATA_DEPTH);
  localparam int PC_W          = $clog2(PROGRAM_DEPTH);
  localparam int NUM_REGS      = 32;
  localparam int IN_TDATA_W    = 72;
  localparam int OUT_TDATA_W   = 96;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDI = 6'd1, OP_AND = 6'd2, OP_ANDI = 6'd3,
    OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BGEZ = 6'd6, OP_BGTZ = 6'd7,
    OP_BLEZ = 6'd8, OP_BLTZ = 6'd9, OP_BGEZAL = 6'd10, OP_BLTZAL = 6'd11,
    OP_DIV = 6'd12, OP_DIVU = 6'd13, OP_J = 6'd14, OP_JR = 6'd15,
    OP_JAL = 6'd16, OP_LW = 6'd17, OP_MFHI = 6'd18, OP_MFLO = 6'd19,
    OP_MULT = 6'd20, OP_MULTU = 6'd21, OP_OR = 6'd22, OP_ORI = 6'd23,
    OP_SW = 6'd24, OP_SUB = 6'd25, OP_SUBI = 6'd26, OP_SUBU = 6'd27,
    OP_SLL = 6'd28, OP_SLLV = 6'd29, OP_SRL = 6'd30, OP_SRLV = 6'd31,
    OP_SRA = 6'd32, OP_SLT = 6'd33, OP_SLTU = 6'd34, OP_SLTI = 6'd35,
    OP_SLTIU = 6'd36, OP_XOR = 6'd37, OP_XORI = 6'd38, OP_NOOP = 6'd39
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_ADDR = 2'd2
  } status_t;

  // first member sits in the highest bits
  typedef struct packed {
    logic [11:0] jump_target;
    logic [4:0]  shift_amount;
    logic [31:0] immediate;
    logic [4:0]  src_b_index;
    logic [4:0]  src_a_index;
    logic [4:0]  dest_index;
    logic [5:0]  req_type;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        mem_value;
    logic [DATA_AW-1:0] mem_address;
    logic               mem_write;
    logic [31:0]        reg_value;
    logic [4:0]         reg_index;
    logic               reg_write;
    logic [PC_W-1:0]    next_pc;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic is_signed;
  } mdu_req_t;

endpackage

// ===== rtl/mseu_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module mseu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mseu_mdu.sv =====
// iterative multiply and divide unit, one shared 33 bit adder, one bit a cycle
// depends on mseu_pkg
module mseu_mdu (
  input  logic              clk,
  input  logic              rst,
  input  mseu_pkg::mdu_req_t req,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [31:0]       hi,
  output logic [31:0]       lo
);
  import mseu_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIX  = 3'b100
  } mstate_t;

  mstate_t     state;
  logic [4:0]  count;
  logic        is_div;
  logic        neg_a;
  logic        neg_b;
  logic [31:0] acc;
  logic [31:0] mq;
  logic [31:0] opnd;
  logic [32:0] add_a;
  logic [32:0] add_b;
  logic [33:0] sum;
  logic [63:0] prod_neg;
  logic        fix_a;
  logic        fix_b;

  assign fix_a = req.is_signed & a[31];
  assign fix_b = req.is_signed & b[31];

  // shared adder: hi + multiplicand, or partial remainder - divisor
  always_comb begin
    if (is_div) begin
      add_a = {acc, mq[31]};
      add_b = ~{1'b0, opnd};
    end else begin
      add_a = {1'b0, acc};
      add_b = mq[0] ? {1'b0, opnd} : 33'd0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {33'd0, is_div};
  end

  assign prod_neg = 64'd0 - {acc, mq};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            is_div <= req.is_div;
            neg_a  <= fix_a;
            neg_b  <= fix_b;
            acc    <= '0;
            mq     <= fix_a ? 32'd0 - a : a;
            opnd   <= fix_b ? 32'd0 - b : b;
            count  <= '0;
            state  <= M_RUN;
          end
        end
        M_RUN: begin
          if (is_div) begin
            acc <= sum[33] ? sum[31:0] : {acc[30:0], mq[31]};
            mq  <= {mq[30:0], sum[33]};
          end else begin
            acc <= sum[32:1];
            mq  <= {sum[0], mq[31:1]};
          end
          count <= count + 5'd1;
          if (count == 5'd31) begin
            state <= M_FIX;
          end
        end
        M_FIX: begin
          // sign fix-up of the magnitudes
          if (is_div) begin
            lo <= (neg_a ^ neg_b) ? 32'd0 - mq : mq;
            hi <= neg_a ? 32'd0 - acc : acc;
          end else if (neg_a ^ neg_b) begin
            {hi, lo} <= prod_neg;
          end else begin
            {hi, lo} <= {acc, mq};
          end
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mips_subset_execute_unit.sv =====
// top level of the mips subset execute unit: sequencer, register file, data memory
// depends on mseu_pkg, mseu_ram, mseu_mdu and mips_subset_execute_unit_defines.svh
//
// usage
// - one decoded instruction per s_ transaction, one result per m_ transaction
// - s_tready is high only while the sequencer is idle; one instruction at a time
// - alu, branch, jump and store instructions: execute state, then done state, from
//   which the result goes to the output register and the sequencer returns to idle
// - lw goes through a load state after execute for the registered data memory read
// - mult, multu, div, divu run 32 steps on the shared adder of the mdu plus
//   a sign fix-up in the muldiv state, then go to the done state
// - divide by zero reports status 1 without starting the mdu, hi and lo untouched
// - the result sits in an output register; a new instruction is taken while it
//   waits, and a finished result waits in the done state until the output register is empty or m_tready frees it
// - reset clears pc, hi, lo and the valid bits of the register file so all
//   registers read zero; data memory is not cleared, no clearing pass
// - register file is two ram copies (one per read port) written together
module mips_subset_execute_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // req_type, dest_index, src_a_index, src_b_index, immediate, shift_amount,
  // jump_target, zero fill
  input  logic [mseu_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // next_pc, reg_write, reg_index, reg_value, mem_write, mem_address, mem_value,
  // status, zero fill
  output logic [mseu_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mseu_pkg::*;

  `include "mips_subset_execute_unit_defines.svh"

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_MULDIV = 5'b00100,
    ST_LOAD   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t        state;
  in_item_t      s_item;
  in_item_t      cur;
  out_item_t     res;
  out_item_t     res_next;
  out_item_t     out_item;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc1;
  logic [31:0]   hi;
  logic [31:0]   lo;
  logic [NUM_REGS-1:0] reg_valid;
  logic [31:0]   rf_qa;
  logic [31:0]   rf_qb;
  logic [31:0]   va;
  logic [31:0]   vb;
  logic          rf_we;
  logic [4:0]    rf_waddr;
  logic [31:0]   rf_wdata;
  logic [31:0]   addr;
  logic          addr_ok;
  logic          dm_we;
  logic [31:0]   dm_q;
  logic          exec_wr;
  logic [31:0]   exec_wv;
  logic          go_load;
  logic          go_mdu;
  mdu_req_t      mdu_req;
  logic          mdu_done;
  logic [31:0]   mdu_hi;
  logic [31:0]   mdu_lo;
  logic          accept;
  logic          out_free;
  op_t           op;

  assign s_item   = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign op       = op_t'(cur.req_type);
  assign pc1      = pc + PC_W'(1);

  // register 0 is never written so its valid bit stays low and it reads zero
  assign va = reg_valid[cur.src_a_index] ? rf_qa : 32'd0;
  assign vb = reg_valid[cur.src_b_index] ? rf_qb : 32'd0;

  assign addr    = va + cur.immediate;
  assign addr_ok = addr < 32'(DATA_DEPTH);

  // execute state logic for everything but the multiply, divide and load data
  always_comb begin
    res_next = '0;
    res_next.next_pc = pc1;
    exec_wr = 1'b0;
    exec_wv = '0;
    res_next.reg_index = cur.dest_index;
    go_load = 1'b0;
    go_mdu  = 1'b0;
    dm_we   = 1'b0;
    case (op)
      OP_ADD:  begin exec_wr = 1'b1; exec_wv = va + vb; end
      OP_ADDI: begin exec_wr = 1'b1; exec_wv = va + cur.immediate; end
      OP_AND:  begin exec_wr = 1'b1; exec_wv = va & vb; end
      OP_ANDI: begin exec_wr = 1'b1; exec_wv = va & cur.immediate; end
      OP_OR:   begin exec_wr = 1'b1; exec_wv = va | vb; end
      OP_ORI:  begin exec_wr = 1'b1; exec_wv = va | cur.immediate; end
      OP_XOR:  begin exec_wr = 1'b1; exec_wv = va ^ vb; end
      OP_XORI: begin exec_wr = 1'b1; exec_wv = va ^ cur.immediate; end
      OP_SUB, OP_SUBU: begin exec_wr = 1'b1; exec_wv = va - vb; end
      OP_SUBI: begin exec_wr = 1'b1; exec_wv = va - cur.immediate; end
      OP_SLL:  begin exec_wr = 1'b1; exec_wv = va << cur.shift_amount; end
      OP_SLLV: begin exec_wr = 1'b1; exec_wv = va << vb[4:0]; end
      OP_SRL:  begin exec_wr = 1'b1; exec_wv = va >> cur.shift_amount; end
      OP_SRLV: begin exec_wr = 1'b1; exec_wv = va >> vb[4:0]; end
      OP_SRA:  begin exec_wr = 1'b1; exec_wv = $signed(va) >>> cur.shift_amount; end
      OP_SLT:  begin exec_wr = 1'b1; exec_wv = {31'd0, $signed(va) < $signed(vb)}; end
      OP_SLTU: begin exec_wr = 1'b1; exec_wv = {31'd0, va < vb}; end
      OP_SLTI: begin
        exec_wr = 1'b1;
        exec_wv = {31'd0, $signed(va) < $signed(cur.immediate)};
      end
      OP_SLTIU: begin exec_wr = 1'b1; exec_wv = {31'd0, va < cur.immediate}; end
      OP_MFHI: begin exec_wr = 1'b1; exec_wv = hi; end
      OP_MFLO: begin exec_wr = 1'b1; exec_wv = lo; end
      OP_BEQ:  if (va == vb) res_next.next_pc = cur.jump_target[PC_W-1:0];
      OP_BNE:  if (va != vb) res_next.next_pc = cur.jump_target[PC_W-1:0];
      OP_BGEZ: if (!va[31]) res_next.next_pc = cur.jump_target[PC_W-1:0];
      OP_BGTZ: if (!va[31] && va != 32'd0) res_next.next_pc = cur.jump_target[PC_W-1:0];
      OP_BLEZ: if (va[31] || va == 32'd0) res_next.next_pc = cur.jump_target[PC_W-1:0];
      OP_BLTZ: if (va[31]) res_next.next_pc = cur.jump_target[PC_W-1:0];
      OP_BGEZAL, OP_BLTZAL: begin
        // link is written whether or not the branch is taken
        exec_wr = 1'b1;
        exec_wv = 32'(pc1);
        res_next.reg_index = LINK_REG;
        if (va[31] == (op == OP_BLTZAL)) res_next.next_pc = cur.jump_target[PC_W-1:0];
      end
      OP_J:    res_next.next_pc = cur.jump_target[PC_W-1:0];
      OP_JR:   res_next.next_pc = va[PC_W-1:0];
      OP_JAL: begin
        exec_wr = 1'b1;
        exec_wv = 32'(pc1);
        res_next.reg_index = LINK_REG;
        res_next.next_pc = cur.jump_target[PC_W-1:0];
      end
      OP_DIV, OP_DIVU: begin
        if (vb == 32'd0) res_next.status = STAT_DIV0;
        else go_mdu = 1'b1;
      end
      OP_MULT, OP_MULTU: go_mdu = 1'b1;
      OP_LW: begin
        if (addr_ok) begin
          go_load = 1'b1;
          res_next.mem_address = addr[DATA_AW-1:0];
        end else begin
          res_next.status = STAT_ADDR;
        end
      end
      OP_SW: begin
        if (addr_ok) begin
          dm_we = 1'b1;
          res_next.mem_write   = 1'b1;
          res_next.mem_address = addr[DATA_AW-1:0];
          res_next.mem_value   = vb;
        end else begin
          res_next.status = STAT_ADDR;
        end
      end
      default: ;
    endcase
    // ops without a register write report index zero
    if (!exec_wr && !go_load) res_next.reg_index = '0;
    // a write to register zero is dropped, index still reported
    res_next.reg_write = exec_wr && (res_next.reg_index != 5'd0);
    res_next.reg_value = res_next.reg_write ? exec_wv : 32'd0;
  end

  // register file write port, shared by the execute and load states
  always_comb begin
    if (state == ST_LOAD) begin
      rf_we    = (res.reg_index != 5'd0);
      rf_waddr = res.reg_index;
      rf_wdata = dm_q;
    end else begin
      rf_we    = (state == ST_EXEC) && res_next.reg_write;
      rf_waddr = res_next.reg_index;
      rf_wdata = res_next.reg_value;
    end
  end

  assign mdu_req.start     = (state == ST_EXEC) && go_mdu;
  assign mdu_req.is_div    = (op == OP_DIV) || (op == OP_DIVU);
  assign mdu_req.is_signed = (op == OP_DIV) || (op == OP_MULT);

  mseu_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (s_item.src_a_index),
    .rdata (rf_qa)
  );

  mseu_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (s_item.src_b_index),
    .rdata (rf_qb)
  );

  mseu_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (dm_we && (state == ST_EXEC)),
    .waddr (addr[DATA_AW-1:0]),
    .wdata (vb),
    .raddr (addr[DATA_AW-1:0]),
    .rdata (dm_q)
  );

  mseu_mdu u_mdu (
    .clk  (clk),
    .rst  (rst),
    .req  (mdu_req),
    .a    (va),
    .b    (vb),
    .done (mdu_done),
    .hi   (mdu_hi),
    .lo   (mdu_lo)
  );

  // instruction sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      hi        <= '0;
      lo        <= '0;
      reg_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // output register: loaded from the done state, cleared when taken
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (rf_we) begin
        reg_valid[rf_waddr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur   <= s_item;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res <= res_next;
          pc  <= res_next.next_pc;
          if (go_mdu) state <= ST_MULDIV;
          else if (go_load) state <= ST_LOAD;
          else state <= ST_DONE;
        end
        ST_MULDIV: begin
          if (mdu_done) begin
            hi    <= mdu_hi;
            lo    <= mdu_lo;
            state <= ST_DONE;
          end
        end
        ST_LOAD: begin
          res.reg_write <= (res.reg_index != 5'd0);
          res.reg_value <= (res.reg_index != 5'd0) ? dm_q : 32'd0;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_item <= res;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {(OUT_TDATA_W - $bits(out_item_t))'(0), out_item};

  // checks
  `MSEU_ASSERT_NOW(a_no_r0_write, rf_we, rf_waddr != 5'd0, "write to register zero")
  `MSEU_ASSERT_NOW(a_mdu_done_state, mdu_done, state == ST_MULDIV, "mdu done out of sequence")
  `MSEU_ASSERT_NEXT(a_accept_exec, accept, state == ST_EXEC, "accept did not start execute")
  `MSEU_ASSERT_NOW(a_div0_no_write, m_tvalid && out_item.status == STAT_DIV0, !out_item.reg_write && !out_item.mem_write, "divide by zero wrote state")

endmodule
